### hw/rtl/hes_pkg.sv
// Shared types, constants and helpers for the heat equation row stencil.
package hes_pkg;

  localparam int GRID_POINTS = 128;
  localparam int POS_W       = 7;
  localparam int IDX_BITS    = $clog2(GRID_POINTS);
  localparam int CNT_W       = (IDX_BITS > POS_W) ? IDX_BITS : POS_W;

  localparam int DATA_W  = 32;
  localparam int FORCE_W = 31;
  localparam int MUL_A_W = 36;
  localparam int MUL_B_W = 19;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int RND_W   = PROD_W - 16;
  localparam int ACC_W   = 40;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN        = 2'd0,
    REG_SPACE_STEP  = 2'd1,
    REG_LEFT_RECIP  = 2'd2,
    REG_RIGHT_RECIP = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LAP,
    S_INNER,
    S_PUT_INNER,
    S_FMUL,
    S_TSUM,
    S_EMUL,
    S_EDGE,
    S_PUT_EDGE
  } seq_state_e;

  typedef struct packed {
    logic [15:0] gain;
    logic [15:0] space_step;
    logic [17:0] left_recip;
    logic [16:0] right_recip;
  } cfg_t;

  typedef struct packed {
    logic                      en;
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } mul_req_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(signed'({1'b0, {(DATA_W-1){1'b1}}}));
    lo = -hi - ACC_W'(1);
    if (v > hi) begin
      sat32 = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (v < lo) begin
      sat32 = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat32 = v[DATA_W-1:0];
    end
  endfunction

endpackage

### hw/rtl/hes_mul.sv
// Shared signed multiplier with registered product and round-half-up by 2^16.
module hes_mul import hes_pkg::*; (
  input  logic                    clk_i,
  input  mul_req_t                req_i,
  output logic signed [RND_W-1:0] rnd_o
);

  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] prod_bias;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= PROD_W'(req_i.a) * PROD_W'(req_i.b);
    end
  end

  // floor(p / 2^16 + 1/2)
  assign prod_bias = prod_q + PROD_W'(32768);
  assign rnd_o     = prod_bias[PROD_W-1:16];

endmodule

### hw/rtl/hes_seq.sv
// Row sequencer: sample history, step control and the output register.
module hes_seq import hes_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cfg_t                    cfg_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [DATA_W-1:0] in_value_i,
  input  logic                    in_end_i,
  input  logic [FORCE_W-1:0]      in_lf_i,
  input  logic [FORCE_W-1:0]      in_rf_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [DATA_W-1:0] out_value_o,
  output logic [POS_W-1:0]        out_pos_o,
  output logic                    out_last_o
);

  seq_state_e state_q, state_d;

  logic signed [DATA_W-1:0] x_q, older_q, recent_q, inner_q, edge_q;
  logic signed [MUL_A_W-1:0] t_q;
  logic [FORCE_W-1:0]        lf_q, rf_q;
  logic                      last_q;
  logic [CNT_W-1:0]          cnt_q, idx_q, idx_m1;

  logic                      in_xfer, in_last, prime;
  logic                      is_first, load_out;
  logic signed [RND_W-1:0]   rnd;
  logic signed [ACC_W-1:0]   rnd_x, inner_sum, t_sum;
  logic signed [MUL_A_W-1:0] lap;
  mul_req_t                  mul_req;

  logic                      out_valid_q;
  logic signed [DATA_W-1:0]  out_value_q;
  logic [POS_W-1:0]          out_pos_q;
  logic                      out_last_q;

  hes_mul u_mul (
    .clk_i (clk_i),
    .req_i (mul_req),
    .rnd_o (rnd)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign in_last    = in_end_i || (cnt_q >= CNT_W'(GRID_POINTS - 1));
  // The first two points of a row only fill history; rows too short to update are dropped.
  assign prime      = (cnt_q < CNT_W'(2)) || ((cnt_q == CNT_W'(2)) && in_last);
  assign is_first   = (idx_q == CNT_W'(2));
  assign idx_m1     = idx_q - CNT_W'(1);

  assign lap       = MUL_A_W'(older_q) + MUL_A_W'(x_q) - (MUL_A_W'(recent_q) <<< 1);
  assign rnd_x     = ACC_W'(rnd);
  assign inner_sum = ACC_W'(recent_q) + rnd_x;
  assign t_sum     = is_first ? (ACC_W'(inner_q) - rnd_x) : (ACC_W'(inner_q) + rnd_x);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:      if (in_xfer && !prime) state_d = S_LAP;
      S_LAP:       state_d = S_INNER;
      S_INNER:     state_d = is_first ? S_FMUL : S_PUT_INNER;
      S_PUT_INNER: begin
        if (!out_valid_q) begin
          state_d = (!is_first && last_q) ? S_FMUL : S_IDLE;
        end
      end
      S_FMUL:      state_d = S_TSUM;
      S_TSUM:      state_d = S_EMUL;
      S_EMUL:      state_d = S_EDGE;
      S_EDGE:      state_d = S_PUT_EDGE;
      S_PUT_EDGE: begin
        if (!out_valid_q) begin
          state_d = is_first ? S_PUT_INNER : S_IDLE;
        end
      end
      default:     state_d = S_IDLE;
    endcase
  end

  // multiplier operands and output load
  always_comb begin
    mul_req  = '0;
    load_out = 1'b0;
    case (state_q)
      S_LAP: begin
        mul_req.en = 1'b1;
        mul_req.a  = lap;
        mul_req.b  = MUL_B_W'(signed'({1'b0, cfg_i.gain}));
      end
      S_FMUL: begin
        mul_req.en = 1'b1;
        mul_req.a  = is_first ? MUL_A_W'(signed'({1'b0, lf_q}))
                              : MUL_A_W'(signed'({1'b0, rf_q}));
        mul_req.b  = MUL_B_W'(signed'({1'b0, cfg_i.space_step}));
      end
      S_EMUL: begin
        mul_req.en = 1'b1;
        mul_req.a  = t_q;
        mul_req.b  = is_first ? MUL_B_W'(signed'({1'b0, cfg_i.left_recip}))
                              : MUL_B_W'(signed'({1'b0, cfg_i.right_recip}));
      end
      S_PUT_INNER, S_PUT_EDGE: load_out = !out_valid_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      older_q     <= '0;
      recent_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_xfer && prime) begin
        if (in_last) begin
          cnt_q <= '0;
        end else begin
          if (cnt_q == '0) older_q <= in_value_i;
          else             recent_q <= in_value_i;
          cnt_q <= cnt_q + CNT_W'(1);
        end
      end
      // Advance the history once the stencil has read it.
      if (state_q == S_INNER) begin
        if (last_q) begin
          cnt_q <= '0;
        end else begin
          older_q  <= recent_q;
          recent_q <= x_q;
          cnt_q    <= idx_q + CNT_W'(1);
        end
      end
      if (load_out)                     out_valid_q <= 1'b1;
      else if (out_ready_i)             out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      x_q    <= in_value_i;
      last_q <= in_last;
      lf_q   <= in_lf_i;
      rf_q   <= in_rf_i;
      idx_q  <= cnt_q;
    end
    if (state_q == S_INNER) inner_q <= sat32(inner_sum);
    if (state_q == S_TSUM)  t_q     <= t_sum[MUL_A_W-1:0];
    if (state_q == S_EDGE)  edge_q  <= sat32(rnd_x);
    if (load_out) begin
      if (state_q == S_PUT_EDGE) begin
        out_value_q <= edge_q;
        out_pos_q   <= is_first ? '0 : idx_q[POS_W-1:0];
        out_last_q  <= !is_first;
      end else begin
        out_value_q <= inner_q;
        out_pos_q   <= idx_m1[POS_W-1:0];
        out_last_q  <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_pos_o   = out_pos_q;
  assign out_last_o  = out_last_q;

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> !out_valid_q) else $error("result register overwritten");
  a_edge_after_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EDGE) |-> ($past(state_q) == S_EMUL)) else $error("edge without product");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(GRID_POINTS - 1)) else $error("point count past row length");
  a_right_edge_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && (state_q == S_PUT_EDGE) && !is_first) |-> last_q)
    else $error("right edge on a row that has not ended");
`endif

endmodule

### hw/rtl/heat_equation_row_stencil.sv
// Heat equation row stencil top level: configuration registers and stream ports.
// Takes the previous time row one point per transfer, left to right, and returns
// the next time row in signed Q15.16 with saturation. The first two points of a row
// give no result and leave the sequencer idle. Every further point runs through one
// shared multiplier under a sequencer: an interior point passes through the product,
// the sum, the output load and the return to idle; the third point adds the left
// edge and the last point the right edge, each with the forcing product, the sum or
// difference, the reciprocal product, the saturation and the output load. The
// input is ready only while the sequencer is idle; a point stalls at its output
// load while the previous result still waits in the output register. A row ends on
// tlast or at point GRID_POINTS-1; a row that ends within three points is dropped.
module heat_equation_row_stencil import hes_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [31:0] old_value, [62:32] left_forcing, [93:63] right_forcing, [95:94] zero
  input  logic [95:0]           s_axis_tdata,
  input  logic                  s_axis_tlast,   // row_end
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [31:0] new_value, [38:32] position, [39] zero
  output logic [39:0]           m_axis_tdata,
  output logic                  m_axis_tlast,   // row_last
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t                     cfg_q;
  logic signed [DATA_W-1:0] out_value;
  logic [POS_W-1:0]         out_pos;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain        <= 16'd32768;
      cfg_q.space_step  <= 16'd2114;
      cfg_q.left_recip  <= 18'd67650;
      cfg_q.right_recip <= 17'd63516;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        REG_GAIN:        cfg_q.gain        <= cfg_data_i[15:0];
        REG_SPACE_STEP:  cfg_q.space_step  <= cfg_data_i[15:0];
        REG_LEFT_RECIP:  cfg_q.left_recip  <= cfg_data_i[17:0];
        REG_RIGHT_RECIP: cfg_q.right_recip <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  hes_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_value_i  (s_axis_tdata[31:0]),
    .in_end_i    (s_axis_tlast),
    .in_lf_i     (s_axis_tdata[62:32]),
    .in_rf_i     (s_axis_tdata[93:63]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_value_o (out_value),
    .out_pos_o   (out_pos),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, out_pos, out_value};

endmodule

### test/heat_equation_row_stencil_monitor.sv
// Stream monitor for the heat equation row stencil: predicts each new row value and compares.
module heat_equation_row_stencil_monitor import hes_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [95:0]           s_axis_tdata,
  input  logic                  s_axis_tlast,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [39:0]           m_axis_tdata,
  input  logic                  m_axis_tlast,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    waiting_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         pos;
    logic                     last;
  } row_point_t;

  row_point_t               new_row_q[$];
  cfg_t                     coef;
  logic signed [DATA_W-1:0] older_val;
  logic signed [DATA_W-1:0] recent_val;
  int unsigned              point_idx;

  initial fail_count_o = 0;
  initial waiting_o = 0;

  // floor(x / 2^16 + 1/2)
  function automatic longint round_q16(longint x);
    return (x + 64'sd32768) >>> 16;
  endfunction

  function automatic logic signed [DATA_W-1:0] clamp_q(longint x);
    if (x > 64'sd2147483647) return 32'h7fff_ffff;
    if (x < -64'sd2147483648) return 32'h8000_0000;
    return x[DATA_W-1:0];
  endfunction

  task automatic step_stencil(logic signed [DATA_W-1:0] x, logic row_end,
                              logic [FORCE_W-1:0] lf, logic [FORCE_W-1:0] rf);
    logic                     last;
    longint                   lap;
    longint                   t;
    logic signed [DATA_W-1:0] inner;
    row_point_t               p;
    last = row_end || (point_idx >= GRID_POINTS - 1);
    if (point_idx < 2 || (point_idx == 2 && last)) begin
      // first two points only fill the window; a row ending this early is dropped
      if (last) begin
        point_idx = 0;
      end else begin
        if (point_idx == 0) older_val = x;
        else recent_val = x;
        point_idx++;
      end
    end else begin
      lap   = longint'(older_val) - 2 * longint'(recent_val) + longint'(x);
      inner = clamp_q(longint'(recent_val) + round_q16(lap * longint'(coef.gain)));
      if (point_idx == 2) begin
        t       = longint'(inner) - round_q16(longint'(coef.space_step) * longint'(lf));
        p.value = clamp_q(round_q16(t * longint'(coef.left_recip)));
        p.pos   = '0;
        p.last  = 1'b0;
        new_row_q.push_back(p);
      end
      p.value = inner;
      p.pos   = POS_W'(point_idx - 1);
      p.last  = 1'b0;
      new_row_q.push_back(p);
      if (last) begin
        t       = longint'(inner) + round_q16(longint'(coef.space_step) * longint'(rf));
        p.value = clamp_q(round_q16(t * longint'(coef.right_recip)));
        p.pos   = POS_W'(point_idx);
        p.last  = 1'b1;
        new_row_q.push_back(p);
        point_idx = 0;
      end else begin
        older_val  = recent_val;
        recent_val = x;
        point_idx++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    row_point_t got;
    row_point_t want;
    if (!rst_ni) begin
      coef.gain        = 16'd32768;
      coef.space_step  = 16'd2114;
      coef.left_recip  = 18'd67650;
      coef.right_recip = 17'd63516;
      older_val        = '0;
      recent_val       = '0;
      point_idx        = 0;
      new_row_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_e'(cfg_index_i))
          REG_GAIN:        coef.gain        = cfg_data_i[15:0];
          REG_SPACE_STEP:  coef.space_step  = cfg_data_i[15:0];
          REG_LEFT_RECIP:  coef.left_recip  = cfg_data_i[17:0];
          REG_RIGHT_RECIP: coef.right_recip = cfg_data_i[16:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        step_stencil(s_axis_tdata[31:0], s_axis_tlast, s_axis_tdata[62:32],
                     s_axis_tdata[93:63]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.value = m_axis_tdata[31:0];
        got.pos   = m_axis_tdata[38:32];
        got.last  = m_axis_tlast;
        if (new_row_q.size() == 0) begin
          $display("%0t: result with nothing expected: value %h pos %0d last %0b",
                   $time, got.value, got.pos, got.last);
          fail_count_o++;
        end else begin
          want = new_row_q.pop_front();
          if (got.value !== want.value) begin
            $display("%0t: new_value expected %h actual %h", $time, want.value, got.value);
            fail_count_o++;
          end
          if (got.pos !== want.pos) begin
            $display("%0t: position expected %0d actual %0d", $time, want.pos, got.pos);
            fail_count_o++;
          end
          if (got.last !== want.last) begin
            $display("%0t: row_last expected %0b actual %0b", $time, want.last, got.last);
            fail_count_o++;
          end
        end
      end
    end
    waiting_o = new_row_q.size();
  end

endmodule

### test/heat_equation_row_stencil_tb.sv
// Top of the heat equation row stencil testbench: stimulus, clock, reset and verdict.
module heat_equation_row_stencil_tb import hes_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 360;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  s_valid     = 1'b0;
  logic                  s_ready;
  logic [95:0]           s_data      = '0;
  logic                  s_last      = 1'b0;
  logic                  m_valid;
  logic                  m_ready     = 1'b0;
  logic [39:0]           m_data;
  logic                  m_last;
  logic                  cfg_valid   = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;

  int fail_count;
  int waiting;
  int idle_pct    = 0;
  int stall_pct   = 0;
  int hold_cycles = 0;
  int cycle_count = 0;

  heat_equation_row_stencil i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tlast  (s_last),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tlast  (m_last),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  heat_equation_row_stencil_monitor i_monitor (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tlast  (s_last),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tlast  (m_last),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .fail_count_o  (fail_count),
    .waiting_o     (waiting)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[heat_equation_row_stencil] ERROR");
      $finish;
    end
  end

  // receiver: long hold-off first, random stalls otherwise
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      m_ready <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 50) return DATA_W'(int'($urandom_range(524288)) - 262144);
    if (r < 80) return $urandom;
    case ($urandom_range(4))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return 32'h0000_0001;
    endcase
  endfunction

  function automatic logic [FORCE_W-1:0] pick_forcing();
    int r;
    r = $urandom_range(99);
    if (r < 60) return FORCE_W'($urandom_range(1 << 23));
    if (r < 90) return FORCE_W'($urandom);
    return (r < 95) ? '0 : {FORCE_W{1'b1}};
  endfunction

  // Called at a falling edge; leaves tvalid high so back-to-back transfers need no toggle.
  task automatic send_point(logic [DATA_W-1:0] v, logic row_end,
                            logic [FORCE_W-1:0] lf, logic [FORCE_W-1:0] rf);
    while ($urandom_range(99) < idle_pct) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {2'b00, rf, lf, v};
    s_last  <= row_end;
    do @(posedge clk_i); while (!s_ready);
    @(negedge clk_i);
  endtask

  task automatic send_row(int len, bit mark_end);
    for (int i = 0; i < len; i++) begin
      send_point(pick_value(), mark_end && (i == len - 1), pick_forcing(), pick_forcing());
    end
  endtask

  task automatic send_rows(int n_items);
    int sent;
    int r;
    int len;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(99);
      if (r < 72) len = $urandom_range(16, 4);
      else if (r < 84) len = $urandom_range(3, 1);
      else if (r < 93) len = $urandom_range(60, 17);
      else if (r < 98) len = $urandom_range(10, 4);
      else len = $urandom_range(130, 126);
      // a few rows run on without tlast into the next one
      send_row(len, !(r >= 93 && r < 98));
      sent += len;
    end
  endtask

  // Drop tvalid, wait for every expected result, then let the pipeline go quiet.
  task automatic settle();
    s_valid <= 1'b0;
    while (waiting != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic configure(logic [CFG_DATA_W-1:0] g, logic [CFG_DATA_W-1:0] hx,
                           logic [CFG_DATA_W-1:0] lr, logic [CFG_DATA_W-1:0] rr);
    cfg_idx_e                idx[4];
    logic [CFG_DATA_W-1:0]   val[4];
    idx = '{REG_GAIN, REG_SPACE_STEP, REG_LEFT_RECIP, REG_RIGHT_RECIP};
    val = '{g, hx, lr, rr};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk_i); while (!cfg_ready);
      @(negedge clk_i);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: rows dropped at each early end, saturating rows, edge forcing extremes
    send_point(32'h0001_0000, 1'b1, '0, '0);
    send_point(32'h0002_0000, 1'b0, '0, '0);
    send_point(32'h0003_0000, 1'b1, '0, '0);
    send_point(32'h0001_0000, 1'b0, '0, '0);
    send_point(32'hffff_0000, 1'b0, '0, '0);
    send_point(32'h0004_0000, 1'b1, {FORCE_W{1'b1}}, {FORCE_W{1'b1}});
    send_point(32'h7fff_ffff, 1'b0, {FORCE_W{1'b1}}, {FORCE_W{1'b1}});
    send_point(32'h8000_0000, 1'b0, {FORCE_W{1'b1}}, {FORCE_W{1'b1}});
    send_point(32'h7fff_ffff, 1'b0, {FORCE_W{1'b1}}, {FORCE_W{1'b1}});
    send_point(32'h8000_0000, 1'b1, {FORCE_W{1'b1}}, {FORCE_W{1'b1}});
    send_point(32'h0000_0000, 1'b0, '0, '0);
    send_point(32'hffff_ffff, 1'b0, '0, '0);
    send_point(32'h7fff_ffff, 1'b0, '0, '0);
    send_point(32'h8000_0000, 1'b0, '0, '0);
    send_point(32'h0000_0001, 1'b1, '0, '0);
    send_point(32'h0001_0000, 1'b0, 31'h0001_0000, 31'h0002_b7e1);
    send_point(32'h0001_2000, 1'b0, 31'h0001_0000, 31'h0002_b7e1);
    send_point(32'h0001_4000, 1'b0, 31'h0001_0000, 31'h0002_b7e1);
    send_point(32'h0001_6000, 1'b1, 31'h0001_0000, 31'h0002_b7e1);
    send_rows(PHASE_ITEMS);
    settle();

    // upper extremes, sender idling
    configure(18'd65535, 18'd65535, 18'd131072, 18'd65536);
    idle_pct = 57;
    send_rows(PHASE_ITEMS);
    settle();

    // lower extremes, receiver stalling
    configure(18'd0, 18'd0, 18'd65536, 18'd32768);
    idle_pct  = 0;
    stall_pct = 57;
    send_rows(PHASE_ITEMS);
    settle();

    // raw values across the whole write width, both sides idling
    configure(18'($urandom_range(262143)), 18'($urandom_range(262143)),
              18'($urandom_range(262143)), 18'($urandom_range(262143)));
    idle_pct  = 27;
    stall_pct = 27;
    send_rows(PHASE_ITEMS);
    settle();

    // receiver holds off while an overlong row keeps coming
    configure(18'($urandom_range(65535)), 18'($urandom_range(65535)),
              18'($urandom_range(131072, 65536)), 18'($urandom_range(65536, 32768)));
    idle_pct    = 0;
    stall_pct   = 0;
    hold_cycles = 400;
    send_row(130, 1'b0);
    send_rows(PHASE_ITEMS - 110);
    settle();

    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[heat_equation_row_stencil] OK");
    end else begin
      $display("[heat_equation_row_stencil] ERROR");
    end
    $finish;
  end

endmodule
